// ===== hdl/fcca_pkg.sv =====
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared widths, operation codes and status codes of the FAT-style cluster
// allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

  // Table geometry
  localparam int unsigned MaxClusters = 4096;
  localparam int unsigned IdxW        = $clog2(MaxClusters);
  localparam int unsigned CntW        = IdxW + 1;
  localparam int unsigned EntryW      = 32;

  localparam logic [EntryW-1:0] EndMark   = '1;
  localparam logic [CntW-1:0]   FirstData = CntW'(2);

  // Operation codes
  localparam int unsigned OpW = 2;
  localparam logic [OpW-1:0] OpAlloc = 2'd0;
  localparam logic [OpW-1:0] OpFree  = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

  // Status codes
  localparam int unsigned StatW = 2;
  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatNoRun    = 2'd1;
  localparam logic [StatW-1:0] StatBadIndex = 2'd2;

endpackage

// ===== hdl/fat_chain_cluster_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fat_chain_cluster_allocator_unit
// FAT-style next-cluster link table with first-fit run allocation, chain free
// and single-entry read, worked one table entry at a time.
// ----------------------------------------------------------------------------
// Sequence: a read steps through ST_READ_RD and ST_READ_DATA to ST_RESP; unused codes and
//   zero runs go straight to ST_RESP; allocate scans and links a run; free walks a chain.
// Transactions: one at a time; the next request is taken in ST_IDLE after the result is
//   posted, and the registered table read gives each entry a read step and a check step.
// Reset: a clearing pass zeroes all 4096 entries with the input not ready; cluster_count
//   resets to 4096.
module fat_chain_cluster_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [fcca_pkg::CntW-1:0]     cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fcca_pkg::OpW-1:0]      operation_i,
  input  logic [fcca_pkg::CntW-1:0]     run_length_i,
  input  logic [fcca_pkg::IdxW-1:0]     cluster_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fcca_pkg::IdxW-1:0]     start_cluster_o,
  output logic [fcca_pkg::EntryW-1:0]   entry_value_o,
  output logic [fcca_pkg::StatW-1:0]    status_o
);
  import fcca_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_CK,
    ST_LINK,
    ST_FREE_CHK,
    ST_FREE_WR,
    ST_READ_RD,
    ST_READ_DATA,
    ST_RESP
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    cluster_count_q;
  logic [IdxW-1:0]    clr_addr_q;
  logic [CntW-1:0]    want_q;
  logic [CntW-1:0]    pos_q;
  logic [CntW-1:0]    run_q;
  logic [IdxW-1:0]    first_q;
  logic [EntryW-1:0]  cur_q;
  logic [CntW-1:0]    steps_q;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    res_start_q;
  logic [EntryW-1:0]  res_entry_q;
  logic [StatW-1:0]   res_status_q;
  logic               out_valid_q;
  logic [IdxW-1:0]    out_start_q;
  logic [EntryW-1:0]  out_entry_q;
  logic [StatW-1:0]   out_status_q;

  // Working limit: cluster_count saturated at the table depth
  logic [CntW-1:0] lim;
  assign lim = (cluster_count_q > CntW'(MaxClusters)) ? CntW'(MaxClusters) : cluster_count_q;

  // Start of the current free run as seen in the scan step
  logic [IdxW-1:0] run_start;
  assign run_start = (run_q == '0) ? pos_q[IdxW-1:0] : first_q;

  // --------------------------------------------------------------------------
  // Link table: one write and one read per cycle, read data registered
  // --------------------------------------------------------------------------
  logic [EntryW-1:0] link_mem [MaxClusters];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [IdxW-1:0]   mem_raddr;
  logic [EntryW-1:0] mem_rdata_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    mem_raddr = pos_q[IdxW-1:0];
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_LINK: begin
        // Chain each cluster to its successor; the last one ends the chain
        mem_we    = 1'b1;
        mem_waddr = pos_q[IdxW-1:0];
        mem_wdata = (run_q == CntW'(1)) ? EndMark : EntryW'(pos_q + CntW'(1));
      end
      ST_FREE_CHK: begin
        mem_raddr = cur_q[IdxW-1:0];
      end
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q[IdxW-1:0];
      end
      ST_READ_RD: begin
        mem_raddr = idx_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= link_mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      cluster_count_q <= CntW'(MaxClusters);
      clr_addr_q      <= '0;
      want_q          <= '0;
      pos_q           <= '0;
      run_q           <= '0;
      first_q         <= '0;
      cur_q           <= '0;
      steps_q         <= '0;
      idx_q           <= '0;
      res_start_q     <= '0;
      res_entry_q     <= '0;
      res_status_q    <= StatOk;
      out_valid_q     <= 1'b0;
      out_start_q     <= '0;
      out_entry_q     <= '0;
      out_status_q    <= StatOk;
    end else begin
      if (cfg_we_i) begin
        cluster_count_q <= cfg_wdata_i;
      end
      // Drop the result once the consumer takes it
      if (out_valid_q && out_ready_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + IdxW'(1);
          if (clr_addr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_valid_i) begin
            res_start_q  <= '0;
            res_entry_q  <= '0;
            res_status_q <= StatOk;
            idx_q        <= cluster_index_i;
            case (operation_i)
              OpAlloc: begin
                if (run_length_i == '0) begin
                  res_status_q <= StatNoRun;
                  state_q      <= ST_RESP;
                end else begin
                  want_q  <= run_length_i;
                  pos_q   <= FirstData;
                  run_q   <= '0;
                  state_q <= ST_ALLOC_RD;
                end
              end
              OpFree: begin
                cur_q   <= EntryW'(cluster_index_i);
                steps_q <= '0;
                state_q <= ST_FREE_CHK;
              end
              OpRead: begin
                if (CntW'(cluster_index_i) < lim) begin
                  state_q <= ST_READ_RD;
                end else begin
                  res_status_q <= StatBadIndex;
                  state_q      <= ST_RESP;
                end
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end

        ST_ALLOC_RD: begin
          // Read of pos_q is issued by the table mux in this state
          if (pos_q >= lim) begin
            res_status_q <= StatNoRun;
            state_q      <= ST_RESP;
          end else begin
            state_q <= ST_ALLOC_CK;
          end
        end

        ST_ALLOC_CK: begin
          if (mem_rdata_q != '0) begin
            run_q   <= '0;
            pos_q   <= pos_q + CntW'(1);
            state_q <= ST_ALLOC_RD;
          end else if (run_q + CntW'(1) == want_q) begin
            // Run found: rewind to its start and link it
            first_q     <= run_start;
            res_start_q <= run_start;
            pos_q       <= CntW'(run_start);
            run_q       <= want_q;
            state_q     <= ST_LINK;
          end else begin
            first_q <= run_start;
            run_q   <= run_q + CntW'(1);
            pos_q   <= pos_q + CntW'(1);
            state_q <= ST_ALLOC_RD;
          end
        end

        ST_LINK: begin
          pos_q <= pos_q + CntW'(1);
          run_q <= run_q - CntW'(1);
          if (run_q == CntW'(1)) begin
            state_q <= ST_RESP;
          end
        end

        ST_FREE_CHK: begin
          if (cur_q == '0 || cur_q == EndMark) begin
            state_q <= ST_RESP;
          end else if (cur_q >= EntryW'(lim)) begin
            res_status_q <= StatBadIndex;
            state_q      <= ST_RESP;
          end else if (steps_q >= lim) begin
            // Loop guard
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_FREE_WR;
          end
        end

        ST_FREE_WR: begin
          // Zero the entry and follow its old link
          cur_q   <= mem_rdata_q;
          steps_q <= steps_q + CntW'(1);
          state_q <= ST_FREE_CHK;
        end

        ST_READ_RD: begin
          state_q <= ST_READ_DATA;
        end

        ST_READ_DATA: begin
          res_entry_q <= mem_rdata_q;
          state_q     <= ST_RESP;
        end

        ST_RESP: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_start_q  <= res_start_q;
            out_entry_q  <= res_entry_q;
            out_status_q <= res_status_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign start_cluster_o = out_start_q;
  assign entry_value_o   = out_entry_q;
  assign status_o        = out_status_q;

`ifndef SYNTHESIS
  // A successful allocation never starts below the first data cluster
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_cluster_o != '0) |-> (status_o == StatOk &&
      CntW'(start_cluster_o) >= FirstData))
    else $error("allocated run starts below first data cluster");

  // Linking stays inside the working limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> (pos_q < lim))
    else $error("link write beyond cluster limit");

  // The free walk never zeroes more entries than the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FREE_WR) |-> (steps_q < lim))
    else $error("free walk exceeded loop guard");

  // No table write while a new transaction may be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_ready_o)
    else $error("table written while idle");

  // Results carry only defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatOk || status_o == StatNoRun ||
      status_o == StatBadIndex))
    else $error("undefined status code");
`endif

endmodule
